// ===== sv/xtscd_pkg.sv =====
package xtscd_pkg;

    localparam int unsigned CountWidth = 16;

    typedef enum logic [3:0] {
        PH_TS0        = 4'd0,
        PH_VAL0       = 4'd1,
        PH_DELTA      = 4'd2,
        PH_DOD_PREFIX = 4'd3,
        PH_DOD_BITS   = 4'd4,
        PH_CTRL1      = 4'd5,
        PH_CTRL2      = 4'd6,
        PH_LEAD       = 4'd7,
        PH_SIG        = 4'd8,
        PH_VBITS      = 4'd9,
        PH_DONE       = 4'd10
    } phase_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_BIT,
        S_FLUSH
    } seq_t;

    localparam logic [3:0] PFX_14 = 4'h2;
    localparam logic [3:0] PFX_17 = 4'h6;
    localparam logic [3:0] PFX_20 = 4'he;
    localparam logic [3:0] PFX_64 = 4'hf;

endpackage

// ===== sv/xor_time_series_chunk_decoder.sv =====
// channel  | ports            | contents (low bit first)
// in       | s_t*             | tdata: data_byte; tuser: start_chunk
// out      | m_t*             | tdata: timestamp, value_bits; tlast: last_of_byte;
//          |                  | tuser: last_sample
// config   | cfg_wr_en/data   | sample_count
// A varint or raw-value byte is accepted, dispatched and flushed; a delta varint adds a step
// for the 64-bit timestamp adder.
// A bit-coded byte is accepted and dispatched, then its bits go MSB first through the shared
// bit parser, with an adder step after each timestamp update, then it is flushed; it ends
// early once the count is reached. A byte arriving after that is accepted and ignored.
// Reset is synchronous, active low; it clears the sample count and decoder state.
// A held result stalls the bit parser while the result port is blocked; flush waits for it.
module xor_time_series_chunk_decoder
    import xtscd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CountWidth-1:0] cfg_wr_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,    // data_byte
    input  logic                  s_tuser,    // start_chunk
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [127:0]          m_tdata,    // timestamp, value_bits
    output logic                  m_tlast,    // last_of_byte
    output logic                  m_tuser     // last_sample
);

    seq_t   seq_reg, seq_next;
    phase_t phase_reg, phase_next;

    logic [CountWidth-1:0] count_reg, count_next;
    logic [CountWidth-1:0] idx_reg, idx_next;
    logic [63:0] ts_reg, ts_next;
    logic [63:0] delta_reg, delta_next;
    logic [63:0] val_reg, val_next;
    logic [4:0]  lead_reg, lead_next;
    logic [6:0]  trail_reg, trail_next;
    logic [63:0] acc_reg, acc_next;
    logic [6:0]  left_reg, left_next;
    logic [6:0]  vsh_reg, vsh_next;
    logic [7:0]  byte_reg, byte_next;
    logic [2:0]  bcnt_reg, bcnt_next;
    logic        add_pend_reg, add_pend_next;

    logic        pv_reg, pv_next;
    logic [63:0] pts_reg, pts_next;
    logic [63:0] pval_reg, pval_next;
    logic        pls_reg, pls_next;

    logic        mv_reg, mv_next;
    logic [63:0] mts_reg, mts_next;
    logic [63:0] mval_reg, mval_next;
    logic        mlb_reg, mlb_next;
    logic        mls_reg, mls_next;

    logic done, out_free, bit_stall, is_byte_phase;

    assign done          = (idx_reg >= count_reg) || (phase_reg >= PH_DONE);
    assign out_free      = !mv_reg || m_tready;
    assign bit_stall     = (seq_reg == S_BIT) && !add_pend_reg && !done && pv_reg && !out_free;
    assign is_byte_phase = phase_reg inside {PH_TS0, PH_VAL0, PH_DELTA};

    assign s_tready = (seq_reg == S_IDLE);
    assign m_tvalid = mv_reg;
    assign m_tdata  = {mval_reg, mts_reg};
    assign m_tlast  = mlb_reg;
    assign m_tuser  = mls_reg;

    always_comb begin
        seq_next = seq_reg;
        case (seq_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    seq_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (done) begin
                    seq_next = S_IDLE;
                end else if (is_byte_phase) begin
                    seq_next = S_FLUSH;
                end else begin
                    seq_next = S_BIT;
                end
            end
            S_BIT: begin
                if (!add_pend_reg) begin
                    if (done) begin
                        seq_next = S_FLUSH;
                    end else if (!bit_stall && bcnt_reg == 3'd0) begin
                        seq_next = S_FLUSH;
                    end
                end
            end
            S_FLUSH: begin
                if (!add_pend_reg && (!pv_reg || out_free)) begin
                    seq_next = S_IDLE;
                end
            end
            default: seq_next = S_IDLE;
        endcase
    end

    always_comb begin
        logic        do_emit;
        logic        bit_in;
        logic [63:0] acc_sh;
        logic [63:0] dv;
        logic [6:0]  sig;
        logic [6:0]  sum;
        logic [6:0]  wsel;
        logic [CountWidth-1:0] idx_inc;

        count_next    = cfg_wr_en ? cfg_wr_data : count_reg;
        phase_next    = phase_reg;
        idx_next      = idx_reg;
        ts_next       = ts_reg;
        delta_next    = delta_reg;
        val_next      = val_reg;
        lead_next     = lead_reg;
        trail_next    = trail_reg;
        acc_next      = acc_reg;
        left_next     = left_reg;
        vsh_next      = vsh_reg;
        byte_next     = byte_reg;
        bcnt_next     = bcnt_reg;
        add_pend_next = add_pend_reg;
        pv_next       = pv_reg;
        pts_next      = pts_reg;
        pval_next     = pval_reg;
        pls_next      = pls_reg;
        mv_next       = mv_reg && !m_tready;
        mts_next      = mts_reg;
        mval_next     = mval_reg;
        mlb_next      = mlb_reg;
        mls_next      = mls_reg;
        do_emit       = 1'b0;
        bit_in        = byte_reg[bcnt_reg];
        acc_sh        = {acc_reg[62:0], bit_in};
        dv            = acc_sh;
        sig           = 7'd0;
        sum           = 7'd0;
        wsel          = 7'd0;
        idx_inc       = idx_reg + 1'b1;

        case (seq_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    byte_next = s_tdata;
                    if (s_tuser) begin
                        idx_next      = '0;
                        ts_next       = '0;
                        delta_next    = '0;
                        val_next      = '0;
                        lead_next     = '0;
                        trail_next    = '0;
                        acc_next      = '0;
                        left_next     = '0;
                        vsh_next      = '0;
                        phase_next    = PH_TS0;
                        add_pend_next = 1'b0;
                    end
                end
            end
            S_DISPATCH: begin
                bcnt_next = 3'd7;
                if (!done && is_byte_phase) begin
                    if (phase_reg == PH_VAL0) begin
                        acc_next = {acc_reg[55:0], byte_reg};
                        if (left_reg <= 7'd8) begin
                            val_next = acc_next;
                            do_emit  = 1'b1;
                        end else begin
                            left_next = left_reg - 7'd8;
                        end
                    end else begin
                        if (vsh_reg < 7'd64) begin
                            acc_next = acc_reg | ({57'd0, byte_reg[6:0]} << vsh_reg[5:0]);
                            vsh_next = vsh_reg + 7'd7;
                        end
                        dv = acc_next;
                        if (!byte_reg[7]) begin
                            vsh_next = '0;
                            acc_next = '0;
                            if (phase_reg == PH_TS0) begin
                                ts_next    = dv[0] ? ~{1'b0, dv[63:1]}
                                                   : {1'b0, dv[63:1]};
                                left_next  = 7'd64;
                                phase_next = PH_VAL0;
                            end else begin
                                delta_next    = dv;
                                add_pend_next = 1'b1;
                                left_next     = '0;
                                phase_next    = PH_CTRL1;
                            end
                        end
                    end
                end
            end
            S_BIT: begin
                if (add_pend_reg) begin
                    ts_next       = ts_reg + delta_reg;
                    add_pend_next = 1'b0;
                end else if (!done && !bit_stall) begin
                    bcnt_next = bcnt_reg - 3'd1;
                    case (phase_reg)
                        PH_DOD_PREFIX: begin
                            acc_next  = acc_sh;
                            left_next = left_reg + 7'd1;
                            if (!bit_in || left_next >= 7'd4) begin
                                case (acc_sh[3:0])
                                    PFX_14:  wsel = 7'd14;
                                    PFX_17:  wsel = 7'd17;
                                    PFX_20:  wsel = 7'd20;
                                    PFX_64:  wsel = 7'd64;
                                    default: wsel = 7'd0;
                                endcase
                                acc_next = '0;
                                if (wsel == 7'd0) begin
                                    left_next     = '0;
                                    add_pend_next = 1'b1;
                                    phase_next    = PH_CTRL1;
                                end else begin
                                    vsh_next   = wsel;
                                    left_next  = wsel;
                                    phase_next = PH_DOD_BITS;
                                end
                            end
                        end
                        PH_DOD_BITS: begin
                            acc_next = acc_sh;
                            if (left_reg > 7'd0) begin
                                left_next = left_reg - 7'd1;
                            end
                            if (left_next == 7'd0) begin
                                case (vsh_reg)
                                    7'd14: if (acc_sh[13:0] > 14'h2000) begin
                                        dv = {{50{1'b1}}, acc_sh[13:0]};
                                    end
                                    7'd17: if (acc_sh[16:0] > 17'h10000) begin
                                        dv = {{47{1'b1}}, acc_sh[16:0]};
                                    end
                                    7'd20: if (acc_sh[19:0] > 20'h80000) begin
                                        dv = {{44{1'b1}}, acc_sh[19:0]};
                                    end
                                    default: dv = acc_sh;
                                endcase
                                delta_next    = delta_reg + dv;
                                add_pend_next = 1'b1;
                                vsh_next      = '0;
                                acc_next      = '0;
                                left_next     = '0;
                                phase_next    = PH_CTRL1;
                            end
                        end
                        PH_CTRL1: begin
                            if (!bit_in) begin
                                do_emit = 1'b1;
                            end else begin
                                phase_next = PH_CTRL2;
                            end
                        end
                        PH_CTRL2: begin
                            if (!bit_in) begin
                                sig        = 7'd64 - {2'b0, lead_reg} - trail_reg;
                                acc_next   = '0;
                                left_next  = sig;
                                phase_next = PH_VBITS;
                                do_emit    = (sig == 7'd0);
                            end else begin
                                acc_next   = '0;
                                left_next  = 7'd5;
                                phase_next = PH_LEAD;
                            end
                        end
                        PH_LEAD: begin
                            acc_next  = acc_sh;
                            left_next = left_reg - 7'd1;
                            if (left_next == 7'd0) begin
                                lead_next  = acc_sh[4:0];
                                acc_next   = '0;
                                left_next  = 7'd6;
                                phase_next = PH_SIG;
                            end
                        end
                        PH_SIG: begin
                            acc_next  = acc_sh;
                            left_next = left_reg - 7'd1;
                            if (left_next == 7'd0) begin
                                sig = (acc_sh[5:0] == 6'd0) ? 7'd64 : {1'b0, acc_sh[5:0]};
                                sum = {2'b0, lead_reg} + sig;
                                if (sum > 7'd64) begin
                                    sig = 7'd64 - {2'b0, lead_reg};
                                end
                                trail_next = 7'd64 - {2'b0, lead_reg} - sig;
                                acc_next   = '0;
                                left_next  = sig;
                                phase_next = PH_VBITS;
                                do_emit    = (sig == 7'd0);
                            end
                        end
                        PH_VBITS: begin
                            acc_next = acc_sh;
                            if (left_reg > 7'd0) begin
                                left_next = left_reg - 7'd1;
                            end
                            if (left_next == 7'd0) begin
                                if (trail_reg < 7'd64) begin
                                    val_next = val_reg ^ (acc_sh << trail_reg[5:0]);
                                end
                                do_emit = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_FLUSH: begin
                if (add_pend_reg) begin
                    ts_next       = ts_reg + delta_reg;
                    add_pend_next = 1'b0;
                end else if (pv_reg && out_free) begin
                    mv_next   = 1'b1;
                    mts_next  = pts_reg;
                    mval_next = pval_reg;
                    mls_next  = pls_reg;
                    mlb_next  = 1'b1;
                    pv_next   = 1'b0;
                end
            end
            default: ;
        endcase

        if (do_emit) begin
            if (pv_reg) begin
                mv_next   = 1'b1;
                mts_next  = pts_reg;
                mval_next = pval_reg;
                mls_next  = pls_reg;
                mlb_next  = 1'b0;
            end
            pv_next   = 1'b1;
            pts_next  = ts_reg;
            pval_next = val_next;
            pls_next  = (idx_inc == count_reg);
            idx_next  = idx_inc;
            acc_next  = '0;
            left_next = '0;
            vsh_next  = '0;
            if (idx_inc >= count_reg) begin
                phase_next = PH_DONE;
            end else if (idx_inc == CountWidth'(1)) begin
                phase_next = PH_DELTA;
            end else begin
                phase_next = PH_DOD_PREFIX;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg      <= S_IDLE;
            phase_reg    <= PH_TS0;
            count_reg    <= '0;
            idx_reg      <= '0;
            ts_reg       <= '0;
            delta_reg    <= '0;
            val_reg      <= '0;
            lead_reg     <= '0;
            trail_reg    <= '0;
            acc_reg      <= '0;
            left_reg     <= '0;
            vsh_reg      <= '0;
            add_pend_reg <= 1'b0;
            pv_reg       <= 1'b0;
            mv_reg       <= 1'b0;
        end else begin
            seq_reg      <= seq_next;
            phase_reg    <= phase_next;
            count_reg    <= count_next;
            idx_reg      <= idx_next;
            ts_reg       <= ts_next;
            delta_reg    <= delta_next;
            val_reg      <= val_next;
            lead_reg     <= lead_next;
            trail_reg    <= trail_next;
            acc_reg      <= acc_next;
            left_reg     <= left_next;
            vsh_reg      <= vsh_next;
            add_pend_reg <= add_pend_next;
            pv_reg       <= pv_next;
            mv_reg       <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg  <= byte_next;
        bcnt_reg  <= bcnt_next;
        pts_reg   <= pts_next;
        pval_reg  <= pval_next;
        pls_reg   <= pls_next;
        mts_reg   <= mts_next;
        mval_reg  <= mval_next;
        mlb_reg   <= mlb_next;
        mls_reg   <= mls_next;
    end

    a_idle_no_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        seq_reg == S_IDLE |-> !pv_reg)
        else $error("held result left behind when the byte finished");

    a_idle_no_add: assert property (@(posedge aclk) disable iff (!aresetn)
        seq_reg == S_IDLE |-> !add_pend_reg)
        else $error("timestamp add outstanding in idle");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        bit_stall |=> $stable(bcnt_reg) && seq_reg == S_BIT)
        else $error("bit parser advanced while the result port was blocked");

    a_flush_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (seq_reg == S_FLUSH && !add_pend_reg && pv_reg && out_free) |=> mv_reg && mlb_reg)
        else $error("final result of a byte not marked");

endmodule
